// ===== hdl/turmite_step_engine_top_assert.svh =====
// assertion macros for the turmite step engine
// no dependencies; included by the top level, which checks its own logic
`ifndef TURMITE_STEP_ENGINE_TOP_ASSERT_SVH
`define TURMITE_STEP_ENGINE_TOP_ASSERT_SVH

// condition in one cycle implies consequence in the next
`define TSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition implies consequence in the same cycle
`define TSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tse_pkg.sv =====
// shared types, codes and defaults of the turmite step engine
// no dependencies
package tse_pkg;

    localparam int MAX_RULES_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int RULE_SLOTS     = 16;   // addressable by the rule state field
    localparam int STATE_W        = 4;
    localparam int POS_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    typedef enum logic [2:0] {
        CMD_STEP    = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_KILL    = 3'd2,
        CMD_RAISE   = 3'd3,
        CMD_RESTART = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2,
        TURN_UTURN = 2'd3
    } t_turn;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X       = 2'd0,
        CFG_START_Y       = 2'd1,
        CFG_START_RULE    = 2'd2,
        CFG_START_HEADING = 2'd3
    } t_cfg_idx;

    // bit layout: next0 in the low nibble up to paint1 on top
    typedef struct packed {
        logic               paint1;
        logic               paint0;
        t_turn              turn1;
        t_turn              turn0;
        logic [STATE_W-1:0] next1;
        logic [STATE_W-1:0] next0;
    } t_rule;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [STATE_W-1:0]      rule;
        t_dir                    heading;
    } t_start;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic color;
    } t_item_ctl;

endpackage

// ===== hdl/turmite_step_engine_top.sv =====
// top level of the turmite step engine: handshake, start registers, result register
// depends on tse_pkg, tse_rule_tbl, tse_head and the assertion macro header
`include "turmite_step_engine_top_assert.svh"

// Two-color turmite. Load the rule table with append words (one rule per word, in
// order), set the start registers while idle, then send restart, step, kill and raise
// words; every word gives one result word. Throughput is one word per clock while the
// sink keeps ready high: a word is captured in the input register, then the head
// update (one read of the flop-based rule table at the current rule state, a 2-bit
// heading add and one coordinate increment or decrement) runs combinationally and
// lands in the head state and the result register together, so the following word
// sees the new state. The result register stalls only when the sink holds ready low.
module turmite_step_engine_top
    import tse_pkg::*;
#(
    parameter int MAX_RULES  = MAX_RULES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_cmd,
    input  logic                  i_cell_color,
    input  logic [3:0]            i_next_if_zero,
    input  logic [3:0]            i_next_if_one,
    input  logic [1:0]            i_turn_if_zero,
    input  logic [1:0]            i_turn_if_one,
    input  logic                  i_paint_if_zero,
    input  logic                  i_paint_if_one,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_paint_color,
    output logic signed [15:0]    o_pos_x,
    output logic signed [15:0]    o_pos_y,
    output logic [1:0]            o_heading,
    output logic [3:0]            o_rule_state,
    output logic                  o_is_alive,
    output logic                  o_moved,
    output logic                  o_table_full
);

    t_start             r_start;

    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic               r_in_color;
    t_rule              r_in_rule;

    logic               r_out_valid;
    logic               r_paint;
    logic [POS_W-1:0]   r_pos_x, r_pos_y;
    t_dir               r_heading;
    logic [STATE_W-1:0] r_rule_state;
    logic               r_alive;
    logic               r_moved;
    logic               r_full;

    logic               w_fire;
    logic               w_append;
    t_item_ctl          w_ctl;
    t_rule              w_rule;
    logic               w_refused;
    logic [STATE_W-1:0] w_addr;
    logic               w_paint, w_moved, w_alive;
    logic [POS_W-1:0]   w_pos_x, w_pos_y;
    t_dir               w_heading;
    logic [STATE_W-1:0] w_rule_state;

    // start registers; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_X:       r_start.x       <= signed'(i_cfg_data);
                CFG_START_Y:       r_start.y       <= signed'(i_cfg_data);
                CFG_START_RULE:    r_start.rule    <= i_cfg_data[STATE_W-1:0];
                CFG_START_HEADING: r_start.heading <= t_dir'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // the compute stage fires when its result has somewhere to go
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd         <= t_cmd'(i_cmd);
            r_in_color       <= i_cell_color;
            r_in_rule.next0  <= i_next_if_zero;
            r_in_rule.next1  <= i_next_if_one;
            r_in_rule.turn0  <= t_turn'(i_turn_if_zero);
            r_in_rule.turn1  <= t_turn'(i_turn_if_one);
            r_in_rule.paint0 <= i_paint_if_zero;
            r_in_rule.paint1 <= i_paint_if_one;
        end
    end

    assign w_append    = w_fire && (r_in_cmd == CMD_APPEND);
    assign w_ctl.valid = w_fire;
    assign w_ctl.cmd   = r_in_cmd;
    assign w_ctl.color = r_in_color;

    tse_rule_tbl #(
        .MAX_RULES (MAX_RULES)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_append  (w_append),
        .i_rule    (r_in_rule),
        .i_addr    (w_addr),
        .o_rule    (w_rule),
        .o_refused (w_refused)
    );

    tse_head #(
        .COORD_BITS (COORD_BITS)
    ) u_head (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_rule       (w_rule),
        .i_start      (r_start),
        .o_rule_addr  (w_addr),
        .o_paint      (w_paint),
        .o_moved      (w_moved),
        .o_pos_x      (w_pos_x),
        .o_pos_y      (w_pos_y),
        .o_heading    (w_heading),
        .o_rule_state (w_rule_state),
        .o_alive      (w_alive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_paint      <= w_paint;
            r_pos_x      <= w_pos_x;
            r_pos_y      <= w_pos_y;
            r_heading    <= w_heading;
            r_rule_state <= w_rule_state;
            r_alive      <= w_alive;
            r_moved      <= w_moved;
            r_full       <= w_append && w_refused;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_paint_color = r_paint;
    assign o_pos_x       = signed'(r_pos_x);
    assign o_pos_y       = signed'(r_pos_y);
    assign o_heading     = r_heading;
    assign o_rule_state  = r_rule_state;
    assign o_is_alive    = r_alive;
    assign o_moved       = r_moved;
    assign o_table_full  = r_full;

    `TSE_ASSERT_NEXT(a_moved_only_on_step, i_clk, i_rst_n,
        w_fire && (r_in_cmd != CMD_STEP), !r_moved, "moved set by a word that is not a step")
    `TSE_ASSERT_NEXT(a_full_only_on_append, i_clk, i_rst_n,
        w_fire && (r_in_cmd != CMD_APPEND), !r_full,
        "table full set by a word that is not an append")
    `TSE_ASSERT_NEXT(a_restart_alive, i_clk, i_rst_n,
        w_fire && (r_in_cmd == CMD_RESTART), r_alive && (r_heading == r_start.heading),
        "restart did not load the head")
    `TSE_ASSERT_NEXT(a_kill_dead, i_clk, i_rst_n,
        w_fire && (r_in_cmd == CMD_KILL), !r_alive, "kill left the head alive")
    `TSE_ASSERT_SAME(a_ready_when_free, i_clk, i_rst_n,
        !r_out_valid, o_in_ready, "input stalled with an empty result register")

endmodule

// ===== hdl/tse_rule_tbl.sv =====
// rule table: flop array filled by appends in order, with fill count
// depends on tse_pkg
module tse_rule_tbl
    import tse_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_append,
    input  t_rule              i_rule,
    input  logic [STATE_W-1:0] i_addr,
    output t_rule              o_rule,
    output logic               o_refused
);

    // entries past the state field range can never be read back
    localparam int TBL_DEPTH = (MAX_RULES < RULE_SLOTS) ? MAX_RULES : RULE_SLOTS;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    t_rule              r_table [0:(2**TBL_AW)-1];
    logic [CNT_W-1:0]   r_count;
    logic               w_store;

    assign o_refused = (r_count >= CNT_W'(MAX_RULES));
    assign w_store   = i_append && !o_refused && (r_count < CNT_W'(TBL_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_append && !o_refused) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_table[r_count[TBL_AW-1:0]] <= i_rule;
        end
    end

    assign o_rule = r_table[i_addr[TBL_AW-1:0]];

endmodule

// ===== hdl/tse_head.sv =====
// head state: position, heading, rule state, alive flag and their update
// depends on tse_pkg
module tse_head
    import tse_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item_ctl          i_ctl,
    input  t_rule              i_rule,
    input  t_start             i_start,
    output logic [STATE_W-1:0] o_rule_addr,
    output logic               o_paint,
    output logic               o_moved,
    output logic [POS_W-1:0]   o_pos_x,
    output logic [POS_W-1:0]   o_pos_y,
    output t_dir               o_heading,
    output logic [STATE_W-1:0] o_rule_state,
    output logic               o_alive
);

    localparam int EXT_W = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;

    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    t_dir                  r_dir, n_dir;
    logic [STATE_W-1:0]    r_rule, n_rule;
    logic                  r_alive, n_alive;

    logic [STATE_W-1:0]    w_next;
    t_turn                 w_turn;
    t_dir                  w_turned;
    logic [EXT_W-1:0]      w_sx, w_sy, w_ox, w_oy;

    assign w_next = i_ctl.color ? i_rule.next1 : i_rule.next0;
    assign w_turn = i_ctl.color ? i_rule.turn1 : i_rule.turn0;
    assign w_sx   = EXT_W'(i_start.x);
    assign w_sy   = EXT_W'(i_start.y);

    always_comb begin
        unique case (w_turn)
            TURN_NONE:  w_turned = r_dir;
            TURN_LEFT:  w_turned = t_dir'(r_dir + 2'd3);
            TURN_RIGHT: w_turned = t_dir'(r_dir + 2'd1);
            TURN_UTURN: w_turned = t_dir'(r_dir + 2'd2);
            default:    w_turned = r_dir;
        endcase
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_dir   = r_dir;
        n_rule  = r_rule;
        n_alive = r_alive;
        o_moved = 1'b0;
        o_paint = 1'b0;
        if (i_ctl.valid) begin
            unique case (i_ctl.cmd)
                CMD_STEP: begin
                    o_paint = i_ctl.color ? i_rule.paint1 : i_rule.paint0;
                    if (r_alive) begin
                        n_dir   = w_turned;
                        n_rule  = w_next;
                        o_moved = 1'b1;
                        // north decreases y
                        unique case (w_turned)
                            DIR_NORTH: n_y = r_y - COORD_BITS'(1);
                            DIR_EAST:  n_x = r_x + COORD_BITS'(1);
                            DIR_SOUTH: n_y = r_y + COORD_BITS'(1);
                            DIR_WEST:  n_x = r_x - COORD_BITS'(1);
                            default:   n_y = r_y + COORD_BITS'(1);
                        endcase
                    end
                end
                CMD_KILL:  n_alive = 1'b0;
                CMD_RAISE: n_alive = 1'b1;
                CMD_RESTART: begin
                    n_x     = w_sx[COORD_BITS-1:0];
                    n_y     = w_sy[COORD_BITS-1:0];
                    n_dir   = i_start.heading;
                    n_rule  = i_start.rule;
                    n_alive = 1'b1;
                end
                default: ;   // append and unused codes leave the head alone
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_dir   <= DIR_NORTH;
            r_rule  <= '0;
            r_alive <= 1'b1;
        end else begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_dir   <= n_dir;
            r_rule  <= n_rule;
            r_alive <= n_alive;
        end
    end

    assign w_ox = EXT_W'(n_x);
    assign w_oy = EXT_W'(n_y);

    assign o_rule_addr  = r_rule;
    assign o_pos_x      = w_ox[POS_W-1:0];
    assign o_pos_y      = w_oy[POS_W-1:0];
    assign o_heading    = n_dir;
    assign o_rule_state = n_rule;
    assign o_alive      = n_alive;

endmodule

// ===== tb/tb_turmite_step_engine_top.sv =====
// self-checking testbench for the turmite step engine top level
// depends on tse_pkg and turmite_step_engine_top; a head tracker predicts every result word
`timescale 1ns / 100ps

module tb_turmite_step_engine_top;
    import tse_pkg::*;

    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
    localparam int unsigned GAP_MAX         = 17;
    localparam int unsigned HOLD_CYCLES     = 250;
    localparam int unsigned PHASE_WORDS     = 385;

    typedef struct packed {
        logic [2:0] cmd;
        logic       color;
        t_rule      rule;
    } t_word;

    typedef struct packed {
        logic        paint;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  heading;
        logic [3:0]  state;
        logic        alive;
        logic        moved;
        logic        full;
    } t_result;

    // tracks the head and the rule table, queues the result word each input word must give
    class head_tracker;
        t_rule       rules[RULE_SLOTS];
        int unsigned rules_in;
        logic [15:0] head_x, head_y;
        t_dir        head_dir;
        logic [3:0]  cur_state;
        bit          alive;
        logic [15:0] start_x, start_y;
        logic [3:0]  start_state;
        t_dir        start_dir;
        t_result     due_results[$];
        int unsigned errors;

        function new();
            rules_in    = 0;
            head_x      = '0;
            head_y      = '0;
            head_dir    = DIR_NORTH;
            cur_state   = '0;
            alive       = 1'b1;
            start_x     = '0;
            start_y     = '0;
            start_state = '0;
            start_dir   = DIR_NORTH;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_START_X:       start_x = data;
                CFG_START_Y:       start_y = data;
                CFG_START_RULE:    start_state = data[3:0];
                CFG_START_HEADING: start_dir = t_dir'(data[1:0]);
                default: ;
            endcase
        endfunction

        // a step must never read a rule that was not appended yet
        function bit step_allowed();
            return cur_state < rules_in;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void take_word(t_word w);
            t_result    r;
            t_rule      e;
            t_turn      trn;
            logic [3:0] nxt;
            r = '0;
            case (w.cmd)
                CMD_STEP: begin
                    e = rules[cur_state];
                    nxt = w.color ? e.next1 : e.next0;
                    trn = w.color ? e.turn1 : e.turn0;
                    r.paint = w.color ? e.paint1 : e.paint0;
                    if (alive) begin
                        case (trn)
                            TURN_LEFT:  head_dir = t_dir'(head_dir - 2'd1);
                            TURN_RIGHT: head_dir = t_dir'(head_dir + 2'd1);
                            TURN_UTURN: head_dir = t_dir'(head_dir + 2'd2);
                            default: ;
                        endcase
                        case (head_dir)
                            DIR_NORTH: head_y = head_y - 16'd1;
                            DIR_EAST:  head_x = head_x + 16'd1;
                            DIR_SOUTH: head_y = head_y + 16'd1;
                            default:   head_x = head_x - 16'd1;
                        endcase
                        cur_state = nxt;
                        r.moved = 1'b1;
                    end
                end
                CMD_APPEND: begin
                    if (rules_in >= MAX_RULES_DEF) begin
                        r.full = 1'b1;
                    end else begin
                        rules[rules_in] = w.rule;
                        rules_in++;
                    end
                end
                CMD_KILL:  alive = 1'b0;
                CMD_RAISE: alive = 1'b1;
                CMD_RESTART: begin
                    head_x    = start_x;
                    head_y    = start_y;
                    head_dir  = start_dir;
                    cur_state = start_state;
                    alive     = 1'b1;
                end
                default: ;
            endcase
            r.x       = head_x;
            r.y       = head_y;
            r.heading = head_dir;
            r.state   = cur_state;
            r.alive   = alive;
            due_results = {due_results, r};
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = due_results.pop_front();
            cmp_field("paint_color", 32'(want.paint), 32'(got.paint));
            cmp_field("pos_x", 32'(want.x), 32'(got.x));
            cmp_field("pos_y", 32'(want.y), 32'(got.y));
            cmp_field("heading", 32'(want.heading), 32'(got.heading));
            cmp_field("rule_state", 32'(want.state), 32'(got.state));
            cmp_field("is_alive", 32'(want.alive), 32'(got.alive));
            cmp_field("moved", 32'(want.moved), 32'(got.moved));
            cmp_field("table_full", 32'(want.full), 32'(got.full));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [2:0]            i_cmd;
    logic                  i_cell_color;
    logic [3:0]            i_next_if_zero;
    logic [3:0]            i_next_if_one;
    logic [1:0]            i_turn_if_zero;
    logic [1:0]            i_turn_if_one;
    logic                  i_paint_if_zero;
    logic                  i_paint_if_one;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_paint_color;
    logic signed [15:0]    o_pos_x;
    logic signed [15:0]    o_pos_y;
    logic [1:0]            o_heading;
    logic [3:0]            o_rule_state;
    logic                  o_is_alive;
    logic                  o_moved;
    logic                  o_table_full;

    head_tracker tracker = new();

    int unsigned in_left   = 0;
    bit          in_quiet  = 1'b0;
    int unsigned out_left  = 0;
    bit          out_quiet = 1'b0;

    turmite_step_engine_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_cell_color    (i_cell_color),
        .i_next_if_zero  (i_next_if_zero),
        .i_next_if_one   (i_next_if_one),
        .i_turn_if_zero  (i_turn_if_zero),
        .i_turn_if_one   (i_turn_if_one),
        .i_paint_if_zero (i_paint_if_zero),
        .i_paint_if_one  (i_paint_if_one),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_paint_color   (o_paint_color),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading       (o_heading),
        .o_rule_state    (o_rule_state),
        .o_is_alive      (o_is_alive),
        .o_moved         (o_moved),
        .o_table_full    (o_table_full)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // stretches of busy traffic with no gaps and stretches of random gaps, picked at random
    function automatic int unsigned draw_gap(inout int unsigned left, inout bit quiet);
        if (left == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
            left  = $urandom_range(8, 60);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic t_word make_word(logic [2:0] cmd, logic color);
        t_word w;
        w.cmd   = cmd;
        w.color = color;
        w.rule  = t_rule'(14'($urandom));
        return w;
    endfunction

    // mostly steps; a step that would read an unloaded rule becomes an append
    function automatic t_word random_word();
        t_word       w;
        int unsigned pick;
        w = make_word(CMD_STEP, 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 62)      w.cmd = CMD_STEP;
        else if (pick < 74) w.cmd = CMD_APPEND;
        else if (pick < 79) w.cmd = CMD_KILL;
        else if (pick < 86) w.cmd = CMD_RAISE;
        else if (pick < 95) w.cmd = CMD_RESTART;
        else                w.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        if (w.cmd == CMD_STEP && !tracker.step_allowed())
            w.cmd = CMD_APPEND;
        return w;
    endfunction

    task automatic send_word(input t_word w);
        int unsigned gap;
        gap = draw_gap(in_left, in_quiet);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= w.cmd;
        i_cell_color    <= w.color;
        i_next_if_zero  <= w.rule.next0;
        i_next_if_one   <= w.rule.next1;
        i_turn_if_zero  <= w.rule.turn0;
        i_turn_if_one   <= w.rule.turn1;
        i_paint_if_zero <= w.rule.paint0;
        i_paint_if_one  <= w.rule.paint1;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_word(w);
    endtask

    task automatic cfg_word(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    task automatic write_start_regs(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] state, input logic [15:0] dir);
        cfg_word(CFG_START_X, x);
        cfg_word(CFG_START_Y, y);
        cfg_word(CFG_START_RULE, state);
        cfg_word(CFG_START_HEADING, dir);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: random stalls, plus two long hold-offs that back the block up
    initial begin
        t_result     got;
        int unsigned stall;
        int unsigned seen;
        seen = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (seen == 300 || seen == 1100)
                stall = HOLD_CYCLES;
            else
                stall = draw_gap(out_left, out_quiet);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.paint   = o_paint_color;
            got.x       = o_pos_x;
            got.y       = o_pos_y;
            got.heading = o_heading;
            got.state   = o_rule_state;
            got.alive   = o_is_alive;
            got.moved   = o_moved;
            got.full    = o_table_full;
            tracker.match_result(got);
            seen++;
        end
    end

    initial begin
        t_word w;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_START_X;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_STEP;
        i_cell_color    = 1'b0;
        i_next_if_zero  = '0;
        i_next_if_one   = '0;
        i_turn_if_zero  = TURN_NONE;
        i_turn_if_one   = TURN_NONE;
        i_paint_if_zero = 1'b0;
        i_paint_if_one  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rule 0: left on color 0, right on color 1
        w = make_word(CMD_APPEND, 1'b0);
        w.rule = '{paint1: 1'b0, paint0: 1'b1, turn1: TURN_RIGHT, turn0: TURN_LEFT,
                   next1: 4'd0, next0: 4'd1};
        send_word(w);
        // rule 1: u-turn on color 0 into the top state, straight on color 1
        w = make_word(CMD_APPEND, 1'b1);
        w.rule = '{paint1: 1'b1, paint0: 1'b0, turn1: TURN_NONE, turn0: TURN_UTURN,
                   next1: 4'd1, next0: 4'd15};
        send_word(w);
        send_word(make_word(CMD_STEP, 1'b0));    // x wraps below zero
        send_word(make_word(CMD_STEP, 1'b1));
        send_word(make_word(CMD_STEP, 1'b0));    // now in an unloaded state
        send_word(make_word(CMD_RESTART, 1'b1));
        send_word(make_word(CMD_KILL, 1'b0));
        send_word(make_word(CMD_STEP, 1'b0));    // dead head still paints
        send_word(make_word(CMD_RAISE, 1'b1));
        send_word(make_word(CMD_STEP, 1'b1));
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_word(make_word(3'(c), 1'($urandom)));
        send_word(make_word(CMD_KILL, 1'b1));
        send_word(make_word(CMD_KILL, 1'b0));
        send_word(make_word(CMD_RAISE, 1'b0));
        send_word(make_word(CMD_RAISE, 1'b1));

        // x wraps at the top going east and back going west
        wait_drained();
        write_start_regs(16'h7FFF, 16'h7FFF, 16'd1, 16'(DIR_EAST));
        send_word(make_word(CMD_RESTART, 1'b0));
        send_word(make_word(CMD_STEP, 1'b1));
        send_word(make_word(CMD_STEP, 1'b0));
        // y wraps at the bottom going north and back going south
        wait_drained();
        write_start_regs(16'h8000, 16'h8000, 16'd1, 16'(DIR_NORTH));
        send_word(make_word(CMD_RESTART, 1'b1));
        send_word(make_word(CMD_STEP, 1'b1));
        send_word(make_word(CMD_STEP, 1'b0));

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: write_start_regs(16'h8000, 16'h7FFF, 16'd15, 16'(DIR_WEST));
                1: write_start_regs(16'h0000, 16'h0000, 16'd0, 16'(DIR_NORTH));
                2: write_start_regs(16'h7FF8 + 16'($urandom_range(0, 15)),
                                    16'($urandom), 16'($urandom), 16'($urandom));
                default: write_start_regs(16'($urandom), 16'h8000 - 16'($urandom_range(0, 7)),
                                          16'($urandom), 16'($urandom));
            endcase
            repeat (PHASE_WORDS) send_word(random_word());
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tse_pkg.sv
hdl/tse_rule_tbl.sv
hdl/tse_head.sv
hdl/turmite_step_engine_top.sv
tb/tb_turmite_step_engine_top.sv
